### sv/dnp_pkg.sv
`timescale 1ns / 1ps

package dnp_pkg;

    // Fixed-point formats
    localparam int FRAC_BITS = 24;   // state words are Q8.24
    localparam int COEF_BITS = 15;   // coefficients are Q0.15 / Q1.15, unsigned
    localparam int OUT_FRAC  = 15;   // output is Q4.15
    localparam int OUT_WIDTH = 19;

    // Configuration register widths
    localparam int RADIUS_WIDTH    = 15;
    localparam int DEN_WIDTH       = 16;
    localparam int PREEMPH_WIDTH   = 15;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
    typedef logic [CFG_DATA_WIDTH-1:0]  cfg_data_t;
    typedef logic signed [OUT_WIDTH-1:0] out_sample_t;

    // Configuration register indexes
    localparam cfg_index_t REG_NOTCH_RADIUS = 2'd0;
    localparam cfg_index_t REG_NOTCH_DEN    = 2'd1;
    localparam cfg_index_t REG_PREEMPH_COEF = 2'd2;

endpackage

### sv/dc_notch_preemphasis.sv
`timescale 1ns / 1ps

// The sample waits in the input register and the notch and pre-emphasis math feeds
// the result register, which holds its result while out_ready is low.
// Throughput: one sample per cycle unless the result side stalls; the filter state is updated as each sample advances.
// Reset (rst_n, async, active low): coefficients and all filter state clear to zero,
// both stages empty. Configuration writes are always ready and take effect at once.
module dc_notch_preemphasis #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int STATE_WIDTH  = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]  sample_in,
    input  logic                            block_end,

    output logic                            out_valid,
    input  logic                            out_ready,
    output dnp_pkg::out_sample_t            sample_out,
    output logic                            block_end_out,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  dnp_pkg::cfg_index_t             cfg_index,
    input  dnp_pkg::cfg_data_t              cfg_data
);
    import dnp_pkg::*;

    localparam int SW        = STATE_WIDTH;
    localparam int WW        = STATE_WIDTH + 18;   // working width for the wide sums and rounding
    localparam int PW        = STATE_WIDTH + 17;   // coefficient product width
    localparam int VIN_SHIFT = FRAC_BITS + 1 - SAMPLE_WIDTH;
    localparam int OUT_SHIFT = FRAC_BITS - OUT_FRAC;

    // Saturate a wide signed value to the signed range of w bits
    function automatic logic signed [WW-1:0] sat_w(input logic signed [WW-1:0] v,
                                                   input int w);
        logic signed [WW-1:0] one;
        logic signed [WW-1:0] hi;
        logic signed [WW-1:0] lo;
        one = WW'(1);
        hi  = (one <<< (w - 1)) - one;
        lo  = -hi - one;
        if (v > hi)
            return hi;
        else if (v < lo)
            return lo;
        else
            return v;
    endfunction

    // Round a coefficient product by 2^-15 (ties up), saturate to state width
    function automatic logic signed [SW-1:0] coef_round(input logic signed [PW-1:0] p);
        logic signed [WW-1:0] t;
        t = (WW'(p) + (WW'(1) <<< (COEF_BITS - 1))) >>> COEF_BITS;
        return SW'(sat_w(t, SW));
    endfunction

    // Configuration registers
    logic [RADIUS_WIDTH-1:0]  radius_reg;
    logic [DEN_WIDTH-1:0]     den_reg;
    logic [PREEMPH_WIDTH-1:0] preemph_reg;

    // Filter state
    logic signed [SW-1:0] notch_a_reg;
    logic signed [SW-1:0] notch_b_reg;
    logic signed [SW-1:0] prev_reg;
    logic signed [SW-1:0] notch_a_next;
    logic signed [SW-1:0] notch_b_next;
    logic signed [SW-1:0] prev_next;

    // Input stage
    logic                           s1_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_sample_reg;
    logic                           s1_end_reg;
    logic                           s1_advance;

    // Result stage
    logic        out_valid_reg;
    out_sample_t sample_out_reg;
    logic        block_end_out_reg;
    out_sample_t sample_out_next;

    // Datapath signals
    logic signed [SW-1:0] vin;
    logic signed [SW-1:0] vout;
    logic signed [SW-1:0] y_notch;
    logic signed [SW-1:0] y;
    logic signed [SW-1:0] den_term;
    logic signed [SW-1:0] pre_term;
    logic signed [SW-1:0] z;
    logic signed [PW-1:0] prod_radius;
    logic signed [PW-1:0] prod_den;
    logic signed [PW-1:0] prod_pre;
    logic signed [WW-1:0] out_wide;

    // Handshake
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign cfg_ready  = 1'b1;

    assign out_valid     = out_valid_reg;
    assign sample_out    = sample_out_reg;
    assign block_end_out = block_end_out_reg;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= '0;
            den_reg     <= '0;
            preemph_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NOTCH_RADIUS: radius_reg  <= cfg_data[RADIUS_WIDTH-1:0];
                REG_NOTCH_DEN:    den_reg     <= cfg_data[DEN_WIDTH-1:0];
                REG_PREEMPH_COEF: preemph_reg <= cfg_data[PREEMPH_WIDTH-1:0];
                default:          ;
            endcase
        end
    end

    // Sample to Q8.24
    assign vin = SW'(sat_w(WW'(s1_sample_reg) <<< VIN_SHIFT, SW));

    // Notch section
    assign vout        = SW'(sat_w(WW'(notch_a_reg) + WW'(vin), SW));
    assign prod_radius = $signed({2'b00, radius_reg}) * vout;
    assign prod_den    = $signed({1'b0, den_reg}) * vout;
    assign y_notch     = coef_round(prod_radius);
    assign den_term    = coef_round(prod_den);
    assign y           = (radius_reg != '0) ? y_notch : vin;

    assign notch_a_next = SW'(sat_w(WW'(notch_b_reg)
                                    + ((WW'(y_notch) - WW'(vin)) <<< 1), SW));
    assign notch_b_next = SW'(sat_w(WW'(vin) - WW'(den_term), SW));

    // Pre-emphasis section
    assign prod_pre  = $signed({2'b00, preemph_reg}) * prev_reg;
    assign pre_term  = coef_round(prod_pre);
    assign z         = (preemph_reg != '0)
                       ? SW'(sat_w(WW'(y) - WW'(pre_term), SW)) : y;
    assign prev_next = y;

    // Output rounding to Q4.15 and saturation
    assign out_wide        = (WW'(z) + (WW'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    assign sample_out_next = OUT_WIDTH'(sat_w(out_wide, OUT_WIDTH));

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_sample_reg <= sample_in;
            s1_end_reg    <= block_end;
        end
    end

    // Filter state update, one sample per advance; a bypassed section's state holds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            notch_a_reg <= '0;
            notch_b_reg <= '0;
            prev_reg    <= '0;
        end
        else if (s1_advance)
        begin
            if (radius_reg != '0)
            begin
                notch_a_reg <= notch_a_next;
                notch_b_reg <= notch_b_next;
            end
            if (preemph_reg != '0)
                prev_reg <= prev_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            sample_out_reg    <= sample_out_next;
            block_end_out_reg <= s1_end_reg;
        end
    end

`ifndef ASSERT_OFF
    // Notch state holds while the notch is bypassed
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && radius_reg == '0) |=> ($stable(notch_a_reg) && $stable(notch_b_reg)))
        else $error("notch state changed while notch bypassed");

    // Pre-emphasis history holds while pre-emphasis is bypassed
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && preemph_reg == '0) |=> $stable(prev_reg))
        else $error("pre-emphasis history changed while bypassed");

    // An empty input stage always takes a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stage empty but not ready");

    // A new result only appears after the input stage held an item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result valid without a sample in the input stage");
`endif

endmodule

### bench/dnp_output_checker.sv
`timescale 1ns / 1ps

module dnp_output_checker #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int STATE_WIDTH  = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]  sample_in,
    input  logic                            block_end,

    input  logic                            out_valid,
    input  logic                            out_ready,
    input  dnp_pkg::out_sample_t            sample_out,
    input  logic                            block_end_out,

    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  dnp_pkg::cfg_index_t             cfg_index,
    input  dnp_pkg::cfg_data_t              cfg_data,

    output int                              errors,
    output int                              pending
);

    import dnp_pkg::*;

    localparam longint STATE_MAX = (longint'(1) <<< (STATE_WIDTH - 1)) - 1;
    localparam longint STATE_MIN = -STATE_MAX - 1;
    localparam longint OUT_MAX   = (longint'(1) <<< (OUT_WIDTH - 1)) - 1;
    localparam longint OUT_MIN   = -OUT_MAX - 1;
    localparam int     IN_SHIFT  = FRAC_BITS + 1 - SAMPLE_WIDTH;
    localparam int     OUT_SHIFT = FRAC_BITS - OUT_FRAC;

    typedef struct packed {
        out_sample_t sample;
        logic        block_end;
    } cond_result_t;

    // Coefficients as last written, and the filter's memory
    longint cfg_radius;
    longint cfg_den;
    longint cfg_emph;
    longint notch_a;
    longint notch_b;
    longint emph_prev;

    cond_result_t expected_samples[$];

    function automatic longint clamp_state(input longint v);
        if (v > STATE_MAX)
            return STATE_MAX;
        if (v < STATE_MIN)
            return STATE_MIN;
        return v;
    endfunction

    // Coefficient times Q8.24 word, rounded half up back to Q8.24
    function automatic longint scale_by_coef(input longint c, input longint v);
        return clamp_state((c * v + (longint'(1) <<< (COEF_BITS - 1))) >>> COEF_BITS);
    endfunction

    // One sample through notch and pre-emphasis; updates the filter memory
    function automatic out_sample_t condition_sample(input logic signed [SAMPLE_WIDTH-1:0] s);
        longint vin;
        longint vout;
        longint y;
        longint z;
        longint o;
        vin = clamp_state(longint'(s) * (longint'(1) <<< IN_SHIFT));
        y   = vin;
        if (cfg_radius != 0)
        begin
            vout    = clamp_state(notch_a + vin);
            y       = scale_by_coef(cfg_radius, vout);
            notch_a = clamp_state(notch_b + 2 * (y - vin));
            notch_b = clamp_state(vin - scale_by_coef(cfg_den, vout));
        end
        z = y;
        if (cfg_emph != 0)
        begin
            z         = clamp_state(y - scale_by_coef(cfg_emph, emph_prev));
            emph_prev = y;
        end
        o = (z + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
        if (o > OUT_MAX)
            o = OUT_MAX;
        if (o < OUT_MIN)
            o = OUT_MIN;
        return out_sample_t'(o);
    endfunction

    // Track config writes, predict on each input, compare on each output
    always @(posedge clk or negedge rst_n)
    begin : monitor
        cond_result_t want;
        cond_result_t got;
        if (!rst_n)
        begin
            cfg_radius = 0;
            cfg_den    = 0;
            cfg_emph   = 0;
            notch_a    = 0;
            notch_b    = 0;
            emph_prev  = 0;
            errors     = 0;
            expected_samples.delete();
            pending    = 0;
        end
        else
        begin
            // config transaction; unknown indexes fall through
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_NOTCH_RADIUS: cfg_radius = longint'(cfg_data[RADIUS_WIDTH-1:0]);
                    REG_NOTCH_DEN:    cfg_den    = longint'(cfg_data[DEN_WIDTH-1:0]);
                    REG_PREEMPH_COEF: cfg_emph   = longint'(cfg_data[PREEMPH_WIDTH-1:0]);
                    default:          ;
                endcase
            end

            // result transaction
            if (out_valid && out_ready)
            begin
                got.sample    = sample_out;
                got.block_end = block_end_out;
                if (expected_samples.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result sample_out=%0d block_end_out=%0b",
                             $time, $signed(got.sample), got.block_end);
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (got.sample !== want.sample)
                    begin
                        errors++;
                        $display("%0t: sample_out expected %0d actual %0d",
                                 $time, $signed(want.sample), $signed(got.sample));
                    end
                    if (got.block_end !== want.block_end)
                    begin
                        errors++;
                        $display("%0t: block_end_out expected %0b actual %0b",
                                 $time, want.block_end, got.block_end);
                    end
                end
            end

            // input transaction
            if (in_valid && in_ready)
            begin
                want.sample    = condition_sample(sample_in);
                want.block_end = block_end;
                expected_samples.push_back(want);
            end

            pending = expected_samples.size();
        end
    end

endmodule

### bench/dc_notch_preemphasis_tb.sv
`timescale 1ns / 1ps

module dc_notch_preemphasis_tb;

    import dnp_pkg::*;

    localparam int SAMPLE_W       = 16;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};
    localparam int RANDOM_ITEMS   = 700;
    localparam int WATCHDOG_LIMIT = 1000;

    // index past the three registers; the block must ignore it
    localparam cfg_index_t REG_NONE = 2'd3;

    logic                       clk;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic                       block_end = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    out_sample_t                sample_out;
    logic                       block_end_out;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    cfg_index_t                 cfg_index = REG_NOTCH_RADIUS;
    cfg_data_t                  cfg_data  = '0;

    int errors;
    int pending;

    int dc_offset  = 0;
    bit calm_in    = 1'b0;
    bit calm_out   = 1'b0;
    int stall_left = 0;
    int pace_count = 0;
    int idle_count = 0;

    dc_notch_preemphasis #(
        .SAMPLE_WIDTH (SAMPLE_W),
        .STATE_WIDTH  (32)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_in     (sample_in),
        .block_end     (block_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sample_out    (sample_out),
        .block_end_out (block_end_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    dnp_output_checker #(
        .SAMPLE_WIDTH (SAMPLE_W),
        .STATE_WIDTH  (32)
    ) output_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_in     (sample_in),
        .block_end     (block_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sample_out    (sample_out),
        .block_end_out (block_end_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mix of extremes, DC offset plus noise, and full-range noise
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r == 0)
            v = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
        else if (r < 6)
            v = dc_offset + int'($urandom_range(0, 4000)) - 2000;
        else
            v = $urandom;
        return v[SAMPLE_W-1:0];
    endfunction

    // Coefficient choice: zero, one, all ones, filter-like values, or any 16 bits
    function automatic cfg_data_t pick_coef(input int width);
        int r;
        int full;
        full = (1 << width) - 1;
        r = $urandom_range(0, 9);
        case (r)
            0, 1:    return '0;
            2:       return cfg_data_t'(full);
            3:       return cfg_data_t'(1);
            4, 5, 6: return cfg_data_t'($urandom_range(30000, 32767));
            default: return cfg_data_t'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic last);
        int gap;
        gap = calm_in ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= value;
        block_end <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input cfg_data_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Reprogram only with the pipeline empty
    task automatic configure(input cfg_data_t radius, input cfg_data_t den,
                             input cfg_data_t emph, input bit poke_unused);
        drain_results();
        repeat (4) @(posedge clk);
        write_reg(REG_NOTCH_RADIUS, radius);
        if (poke_unused)
            write_reg(REG_NONE, cfg_data_t'($urandom_range(0, 65535)));
        write_reg(REG_NOTCH_DEN, den);
        write_reg(REG_PREEMPH_COEF, emph);
        cfg_valid <= 1'b0;
    endtask

    // Result side pacing, with stall-free stretches
    always @(posedge clk)
    begin : sink_pacing
        if (pace_count == 0)
        begin
            calm_out   = ($urandom_range(0, 2) == 0);
            pace_count = 300;
        end
        pace_count--;
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!calm_out && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    // Watchdog: too long without any transaction
    initial
    begin : watchdog
        while (idle_count < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_count = 0;
            else
                idle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        int phase_items;
        int sent;
        int k;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Both stages bypassed after reset: straight conversion and rounding
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample('0, 1'b0);
        send_sample(16'sd1, 1'b1);
        send_sample(-16'sd1, 1'b0);

        // Notch only, full-scale coefficients; the set top bit is ignored by the radius register
        configure(16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);

        // Pre-emphasis only, at its largest coefficient
        configure(16'h0000, 16'h0000, 16'hFFFF, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);

        // Typical DC notch and pre-emphasis, plus a write to an unused index
        configure(16'd32440, 16'd32113, 16'd29491, 1'b1);
        send_sample(16'sd4000, 1'b0);
        send_sample(16'sd4100, 1'b0);
        send_sample(16'sd3900, 1'b0);
        drain_results();
        send_sample(-16'sd12000, 1'b0);
        send_sample(16'sd20000, 1'b0);
        send_sample(16'sd0, 1'b1);

        // Random phases, each with fresh coefficients and signal character
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            configure(pick_coef(RADIUS_WIDTH), pick_coef(DEN_WIDTH),
                      pick_coef(PREEMPH_WIDTH), $urandom_range(0, 2) == 0);
            dc_offset   = int'($urandom_range(0, 16000)) - 8000;
            calm_in     = ($urandom_range(0, 3) == 0);
            phase_items = $urandom_range(50, 120);
            for (k = 0; k < phase_items; k++)
            begin
                if ($urandom_range(0, 199) == 0)
                    drain_results();
                send_sample(pick_sample(), $urandom_range(0, 31) == 0);
            end
            sent += phase_items;
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
sv/dnp_pkg.sv
sv/dc_notch_preemphasis.sv
bench/dnp_output_checker.sv
bench/dc_notch_preemphasis_tb.sv
